// ===== rtl/core/ffba_pkg.sv =====
`default_nettype none
package ffba_pkg;

   localparam int KIND_W       = 2;
   localparam int STATUS_W     = 3;
   localparam int LEN_W        = 21;
   localparam int FIELD_ADDR_W = 20;
   localparam int PAGES_W      = 9;
   // pages (9 bits) times a page size of up to 17 bits
   localparam int MUL_W        = 26;

   localparam logic [PAGES_W-1:0] PAGES_RESET = 9'd256;
   localparam logic [LEN_W-1:0]   SIZE_MAX    = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_INIT  = 2'd0,
      KIND_ALLOC = 2'd1,
      KIND_FREE  = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_ZERO_SIZE  = 3'd1,
      ST_NO_INIT    = 3'd2,
      ST_NO_FIT     = 3'd3,
      ST_NOT_FOUND  = 3'd4,
      ST_TABLE_FULL = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      IDX_HOLD     = 3'd0,
      IDX_ZERO     = 3'd1,
      IDX_INC      = 3'd2,
      IDX_DEC      = 3'd3,
      IDX_FREE_TOP = 3'd4,
      IDX_LIVE_TOP = 3'd5
   } idx_op_type;

   typedef enum logic [2:0] {
      FW_NONE   = 3'd0,
      FW_INIT   = 3'd1,
      FW_SHRINK = 3'd2,
      FW_SHIFT  = 3'd3,
      FW_HEAD   = 3'd4
   } free_wr_type;

   typedef enum logic [1:0] {
      LW_NONE     = 2'd0,
      LW_SHIFT_DN = 2'd1,
      LW_SHIFT_UP = 2'd2,
      LW_HEAD     = 2'd3
   } live_wr_type;

   typedef struct packed {
      logic        latch;
      idx_op_type  idx_op;
      free_wr_type free_wr;
      live_wr_type live_wr;
      logic        hold_free;
      logic        hold_live;
      logic        free_inc;
      logic        live_inc;
      logic        live_dec;
      logic        rsp_en;
      status_type  rsp_status;
      logic        rsp_alloc;
      logic        rsp_query;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     req_zero;
      logic     ready;
      logic     free_empty;
      logic     live_empty;
      logic     free_full;
      logic     live_full;
      logic     fit;
      logic     match;
      logic     idx_zero;
      logic     free_last;
      logic     live_last;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/core/ffba_dpath.sv =====
`default_nettype none
module ffba_dpath #(
   parameter int FREE_ENTRIES = 16,
   parameter int LIVE_ENTRIES = 16,
   parameter int PAGE_BYTES   = 4096,
   parameter int ADDR_BITS    = 20
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ffba_pkg::dp_cmd_type              cmd,
   output ffba_pkg::dp_status_type                stat,
   input  wire logic [ffba_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [ffba_pkg::LEN_W-1:0]        req_request_size,
   input  wire logic [ffba_pkg::FIELD_ADDR_W-1:0] req_block_addr,
   input  wire logic [ffba_pkg::PAGES_W-1:0]      region_pages,
   output logic                                   rsp_valid,
   output logic [ffba_pkg::STATUS_W-1:0]          rsp_status,
   output logic [ffba_pkg::FIELD_ADDR_W-1:0]      rsp_result_addr,
   output logic [ffba_pkg::LEN_W-1:0]             rsp_result_size,
   output logic                                   rsp_is_valid
);
   import ffba_pkg::*;

   localparam int FIW = $clog2(FREE_ENTRIES);
   localparam int LIW = $clog2(LIVE_ENTRIES);
   localparam int IW  = (FIW > LIW) ? FIW : LIW;
   localparam int XW  = IW + 1;
   localparam int FCW = $clog2(FREE_ENTRIES + 1);
   localparam int LCW = $clog2(LIVE_ENTRIES + 1);
   localparam int AW  = ADDR_BITS;
   localparam int CW  = (AW > FIELD_ADDR_W) ? AW : FIELD_ADDR_W;
   localparam int EW  = AW + LEN_W;

   // table entries are {start, length}
   logic [EW-1:0] free_mem [FREE_ENTRIES];
   logic [EW-1:0] live_mem [LIVE_ENTRIES];
   logic [EW-1:0] rd_free_ff, rd_live_ff;

   logic [IW-1:0]  idx_ff, idx_in, idx_dec;
   logic [XW-1:0]  idx_inc_x, free_top_x, live_top_x;
   logic [FCW-1:0] free_count_ff;
   logic [LCW-1:0] live_count_ff;
   logic           ready_ff;

   kind_type                  kind_ff;
   logic [LEN_W-1:0]          req_ff;
   logic [FIELD_ADDR_W-1:0]   addr_ff;
   logic [AW-1:0]             hold_start_ff;
   logic [LEN_W-1:0]          hold_len_ff;
   logic [CW-1:0]             hold_ext;

   logic                      rsp_valid_ff;
   status_type                rsp_status_ff;
   logic [FIELD_ADDR_W-1:0]   rsp_addr_ff;
   logic [LEN_W-1:0]          rsp_size_ff;
   logic                      rsp_is_valid_ff;

   logic [AW-1:0]    rd_free_start, rd_live_start, shr_start;
   logic [LEN_W-1:0] rd_free_len, rd_live_len, shr_len, init_len;
   logic [MUL_W-1:0] region_bytes;

   logic            free_we, live_we;
   logic [FIW-1:0]  free_wa;
   logic [LIW-1:0]  live_wa;
   logic [EW-1:0]   free_wd, live_wd;

   assign rd_free_start = rd_free_ff[EW-1:LEN_W];
   assign rd_free_len   = rd_free_ff[LEN_W-1:0];
   assign rd_live_start = rd_live_ff[EW-1:LEN_W];
   assign rd_live_len   = rd_live_ff[LEN_W-1:0];

   assign shr_start = AW'(rd_free_start + AW'(req_ff));   // wraps modulo 2^AW
   assign shr_len   = rd_free_len - req_ff;

   assign region_bytes = MUL_W'(region_pages) * MUL_W'(PAGE_BYTES);
   assign init_len = (region_bytes > MUL_W'(SIZE_MAX)) ? SIZE_MAX
                                                       : region_bytes[LEN_W-1:0];

   assign idx_inc_x  = XW'(idx_ff) + XW'(1);
   assign idx_dec    = idx_ff - IW'(1);
   assign free_top_x = XW'(free_count_ff) - XW'(1);
   assign live_top_x = XW'(live_count_ff) - XW'(1);

   always_comb begin
      case (cmd.idx_op)
         IDX_HOLD:     idx_in = idx_ff;
         IDX_ZERO:     idx_in = '0;
         IDX_INC:      idx_in = idx_inc_x[IW-1:0];
         IDX_DEC:      idx_in = idx_dec;
         IDX_FREE_TOP: idx_in = free_top_x[IW-1:0];
         IDX_LIVE_TOP: idx_in = live_top_x[IW-1:0];
         default:      idx_in = idx_ff;
      endcase
   end

   always_comb begin
      free_we = 1'b1;
      free_wa = '0;
      free_wd = {{AW{1'b0}}, init_len};
      case (cmd.free_wr)
         FW_NONE:   free_we = 1'b0;
         FW_INIT:   free_wd = {{AW{1'b0}}, init_len};
         FW_SHRINK: begin
            free_wa = idx_ff[FIW-1:0];
            free_wd = {shr_start, shr_len};
         end
         FW_SHIFT: begin
            free_wa = idx_inc_x[FIW-1:0];
            free_wd = rd_free_ff;
         end
         FW_HEAD:   free_wd = {hold_start_ff, hold_len_ff};
         default:   free_we = 1'b0;
      endcase
   end

   always_comb begin
      live_we = 1'b1;
      live_wa = '0;
      live_wd = {hold_start_ff, req_ff};
      case (cmd.live_wr)
         LW_NONE:     live_we = 1'b0;
         LW_SHIFT_DN: begin
            live_wa = idx_inc_x[LIW-1:0];
            live_wd = rd_live_ff;
         end
         LW_SHIFT_UP: begin
            live_wa = idx_dec[LIW-1:0];
            live_wd = rd_live_ff;
         end
         LW_HEAD:     live_wd = {hold_start_ff, req_ff};
         default:     live_we = 1'b0;
      endcase
   end

   // read address is the next index, so read data always belongs to idx_ff
   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_wa] <= free_wd;
      end
      rd_free_ff <= free_mem[idx_in[FIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (live_we) begin
         live_mem[live_wa] <= live_wd;
      end
      rd_live_ff <= live_mem[idx_in[LIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         free_count_ff <= '0;
         live_count_ff <= '0;
         ready_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= cmd.rsp_en;
         if (cmd.free_wr == FW_INIT) begin
            free_count_ff <= FCW'(1);
            live_count_ff <= '0;
            ready_ff      <= 1'b1;
         end else begin
            if (cmd.free_inc) begin
               free_count_ff <= free_count_ff + FCW'(1);
            end
            if (cmd.live_inc) begin
               live_count_ff <= live_count_ff + LCW'(1);
            end else if (cmd.live_dec) begin
               live_count_ff <= live_count_ff - LCW'(1);
            end
         end
      end
   end

   assign hold_ext = CW'(hold_start_ff);

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= kind_type'(req_kind);
         req_ff  <= req_request_size;
         addr_ff <= req_block_addr;
      end
      if (cmd.hold_free) begin
         hold_start_ff <= rd_free_start;
      end else if (cmd.hold_live) begin
         hold_start_ff <= rd_live_start;
         hold_len_ff   <= rd_live_len;
      end
      if (cmd.rsp_en) begin
         rsp_status_ff   <= cmd.rsp_status;
         rsp_addr_ff     <= cmd.rsp_alloc ? hold_ext[FIELD_ADDR_W-1:0] : '0;
         rsp_size_ff     <= cmd.rsp_query ? rd_live_len : '0;
         rsp_is_valid_ff <= cmd.rsp_query;
      end
   end

   always_comb begin
      stat.kind       = kind_ff;
      stat.req_zero   = (req_ff == '0);
      stat.ready      = ready_ff;
      stat.free_empty = (free_count_ff == '0);
      stat.live_empty = (live_count_ff == '0);
      stat.free_full  = (XW'(free_count_ff) >= XW'(FREE_ENTRIES));
      stat.live_full  = (XW'(live_count_ff) >= XW'(LIVE_ENTRIES));
      stat.fit        = (rd_free_len >= req_ff);
      stat.match      = (CW'(rd_live_start) == CW'(addr_ff));
      stat.idx_zero   = (idx_ff == '0);
      stat.free_last  = (idx_inc_x >= XW'(free_count_ff));
      stat.live_last  = (idx_inc_x >= XW'(live_count_ff));
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_addr = rsp_addr_ff;
   assign rsp_result_size = rsp_size_ff;
   assign rsp_is_valid    = rsp_is_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/core/ffba_ctrl.sv =====
`default_nettype none
module ffba_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire ffba_pkg::dp_status_type stat,
   output ffba_pkg::dp_cmd_type         cmd
);
   import ffba_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DECODE = 9'b000000010,
      S_FSCAN  = 9'b000000100,
      S_LSHDN  = 9'b000001000,
      S_LHEAD  = 9'b000010000,
      S_LSCAN  = 9'b000100000,
      S_LSHUP  = 9'b001000000,
      S_FSHDN  = 9'b010000000,
      S_FHEAD  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.idx_op     = IDX_HOLD;
      cmd.free_wr    = FW_NONE;
      cmd.live_wr    = LW_NONE;
      cmd.rsp_status = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch  = 1'b1;
               cmd.idx_op = IDX_ZERO;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.kind)
               KIND_INIT: begin
                  cmd.free_wr = FW_INIT;
                  cmd.rsp_en  = 1'b1;
                  state_in    = S_IDLE;
               end
               KIND_ALLOC: begin
                  if (stat.req_zero) begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = ST_ZERO_SIZE;
                     state_in       = S_IDLE;
                  end else if (!stat.ready) begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = ST_NO_INIT;
                     state_in       = S_IDLE;
                  end else if (stat.free_empty) begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = ST_NO_FIT;
                     state_in       = S_IDLE;
                  end else begin
                     state_in = S_FSCAN;
                  end
               end
               KIND_FREE, KIND_QUERY: begin
                  if (!stat.ready) begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = ST_NO_INIT;
                     state_in       = S_IDLE;
                  end else if (stat.live_empty) begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = ST_NOT_FOUND;
                     state_in       = S_IDLE;
                  end else begin
                     state_in = S_LSCAN;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_FSCAN: begin
            if (stat.fit) begin
               if (stat.live_full) begin
                  cmd.rsp_en     = 1'b1;
                  cmd.rsp_status = ST_TABLE_FULL;
                  state_in       = S_IDLE;
               end else begin
                  cmd.free_wr   = FW_SHRINK;
                  cmd.hold_free = 1'b1;
                  if (stat.live_empty) begin
                     state_in = S_LHEAD;
                  end else begin
                     cmd.idx_op = IDX_LIVE_TOP;
                     state_in   = S_LSHDN;
                  end
               end
            end else if (stat.free_last) begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = ST_NO_FIT;
               state_in       = S_IDLE;
            end else begin
               cmd.idx_op = IDX_INC;
            end
         end
         S_LSHDN: begin
            cmd.live_wr = LW_SHIFT_DN;
            if (stat.idx_zero) begin
               state_in = S_LHEAD;
            end else begin
               cmd.idx_op = IDX_DEC;
            end
         end
         S_LHEAD: begin
            cmd.live_wr   = LW_HEAD;
            cmd.live_inc  = 1'b1;
            cmd.rsp_en    = 1'b1;
            cmd.rsp_alloc = 1'b1;
            state_in      = S_IDLE;
         end
         S_LSCAN: begin
            if (stat.match) begin
               if (stat.kind == KIND_QUERY) begin
                  cmd.rsp_en    = 1'b1;
                  cmd.rsp_query = 1'b1;
                  state_in      = S_IDLE;
               end else if (stat.free_full) begin
                  cmd.rsp_en     = 1'b1;
                  cmd.rsp_status = ST_TABLE_FULL;
                  state_in       = S_IDLE;
               end else begin
                  cmd.hold_live = 1'b1;
                  if (stat.live_last) begin
                     cmd.live_dec = 1'b1;
                     if (stat.free_empty) begin
                        state_in = S_FHEAD;
                     end else begin
                        cmd.idx_op = IDX_FREE_TOP;
                        state_in   = S_FSHDN;
                     end
                  end else begin
                     cmd.idx_op = IDX_INC;
                     state_in   = S_LSHUP;
                  end
               end
            end else if (stat.live_last) begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = ST_NOT_FOUND;
               state_in       = S_IDLE;
            end else begin
               cmd.idx_op = IDX_INC;
            end
         end
         S_LSHUP: begin
            cmd.live_wr = LW_SHIFT_UP;
            if (stat.live_last) begin
               cmd.live_dec = 1'b1;
               if (stat.free_empty) begin
                  state_in = S_FHEAD;
               end else begin
                  cmd.idx_op = IDX_FREE_TOP;
                  state_in   = S_FSHDN;
               end
            end else begin
               cmd.idx_op = IDX_INC;
            end
         end
         S_FSHDN: begin
            cmd.free_wr = FW_SHIFT;
            if (stat.idx_zero) begin
               state_in = S_FHEAD;
            end else begin
               cmd.idx_op = IDX_DEC;
            end
         end
         S_FHEAD: begin
            cmd.free_wr  = FW_HEAD;
            cmd.free_inc = 1'b1;
            cmd.rsp_en   = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/core/first_fit_block_allocator_unit.sv =====
`default_nettype none
// First-fit byte allocator over a region of region_pages * PAGE_BYTES bytes (saturating
// at 2^21-1), addresses as byte offsets. A request is taken when start is high and busy
// is low; exactly one response follows, shown for one cycle with rsp_valid high. The
// receiver cannot stall, so rsp_valid must be sampled on every cycle. Init and early
// rejects answer straight from decode. Allocate scans the free table up to the first
// fitting entry, shifts the live table down and writes the new block at its head, or
// stops at the fit when the live table is full; free scans the live table for the
// match, shifts the later live entries up, then shifts the free table down and writes
// the freed block at its head, or stops at the match when the free table is full;
// query stops at the match. A scan that finds nothing answers at its last entry. Each
// table has a single read and write port, so the first-fit scan, the live lookup and
// the head insertions walk one entry a cycle. A new request may be issued in the cycle
// that carries the previous response. The region_pages register is written over csr_*,
// always ready, and must only change while busy is low and no response is pending.
module first_fit_block_allocator_unit #(
   parameter int FREE_ENTRIES = 16,
   parameter int LIVE_ENTRIES = 16,
   parameter int PAGE_BYTES   = 4096,
   parameter int ADDR_BITS    = 20
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [ffba_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [ffba_pkg::LEN_W-1:0]        req_request_size,
   input  wire logic [ffba_pkg::FIELD_ADDR_W-1:0] req_block_addr,
   // response channel
   output logic                                   rsp_valid,
   output logic [ffba_pkg::STATUS_W-1:0]          rsp_status,
   output logic [ffba_pkg::FIELD_ADDR_W-1:0]      rsp_result_addr,
   output logic [ffba_pkg::LEN_W-1:0]             rsp_result_size,
   output logic                                   rsp_is_valid,
   // region size register
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ffba_pkg::PAGES_W-1:0]      csr_data
);
   import ffba_pkg::*;

   logic [PAGES_W-1:0] region_pages_ff;
   dp_cmd_type         cmd;
   dp_status_type      stat;

   // register is always writable; only read by an init request
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_pages_ff <= PAGES_RESET;
      end else if (csr_valid && csr_ready) begin
         region_pages_ff <= csr_data;
      end
   end

   // sequencer: scan, shift and head-insert steps
   ffba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // tables, counts, request latch and response register
   ffba_dpath #(
      .FREE_ENTRIES (FREE_ENTRIES),
      .LIVE_ENTRIES (LIVE_ENTRIES),
      .PAGE_BYTES   (PAGE_BYTES),
      .ADDR_BITS    (ADDR_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_kind),
      .req_request_size (req_request_size),
      .req_block_addr   (req_block_addr),
      .region_pages     (region_pages_ff),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_result_addr  (rsp_result_addr),
      .rsp_result_size  (rsp_result_size),
      .rsp_is_valid     (rsp_is_valid)
   );

`ifndef ASSERT_OFF
   // an accepted request always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but sequencer stayed idle");

   // a response is only produced as a request finishes
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("response without a finishing request");

   // is_valid only on a successful query
   a_valid_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_valid) |-> (rsp_status == ST_OK && rsp_result_addr == '0))
      else $error("query validity flag on a non-query response");
`endif

endmodule
`default_nettype wire

// ===== tb/ffba_reply_checker.sv =====
`timescale 1ns / 1ps
// Watches the request, response and region size channels, keeps its own copy of
// both tables and compares every response with the oldest outstanding prediction.
module ffba_reply_checker #(
   parameter int FREE_ENTRIES = 16,
   parameter int LIVE_ENTRIES = 16,
   parameter int PAGE_BYTES   = 4096,
   parameter int ADDR_BITS    = 20
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic                              busy,
   input  wire logic [ffba_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [ffba_pkg::LEN_W-1:0]        req_request_size,
   input  wire logic [ffba_pkg::FIELD_ADDR_W-1:0] req_block_addr,
   input  wire logic                              rsp_valid,
   input  wire logic [ffba_pkg::STATUS_W-1:0]     rsp_status,
   input  wire logic [ffba_pkg::FIELD_ADDR_W-1:0] rsp_result_addr,
   input  wire logic [ffba_pkg::LEN_W-1:0]        rsp_result_size,
   input  wire logic                              rsp_is_valid,
   input  wire logic                              csr_valid,
   input  wire logic                              csr_ready,
   input  wire logic [ffba_pkg::PAGES_W-1:0]      csr_data,
   output int                                     mismatches,
   output int                                     outstanding
);
   import ffba_pkg::*;

   localparam longint ADDR_MASK = (longint'(1) << ADDR_BITS) - 1;

   typedef struct packed {
      status_type              status;
      logic [FIELD_ADDR_W-1:0] addr;
      logic [LEN_W-1:0]        size;
      logic                    valid;
   } alloc_reply_type;

   logic [FIELD_ADDR_W-1:0] free_base [FREE_ENTRIES];
   logic [LEN_W-1:0]        free_len  [FREE_ENTRIES];
   logic [FIELD_ADDR_W-1:0] live_base [LIVE_ENTRIES];
   logic [LEN_W-1:0]        live_len  [LIVE_ENTRIES];
   int                      free_used;
   int                      live_used;
   bit                      table_ready;
   logic [PAGES_W-1:0]      region_pages;
   alloc_reply_type         expected_replies [$];

   task automatic flag_mismatch(input string what, input longint unsigned got,
                                input longint unsigned want);
      if (mismatches < 200)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // head-nearest live block at this offset, or live_used when there is none
   function automatic int find_live_block(input logic [FIELD_ADDR_W-1:0] addr);
      for (int i = 0; i < live_used; i++)
         if (live_base[i] == addr)
            return i;
      return live_used;
   endfunction

   task automatic predict_reply(input kind_type kind, input logic [LEN_W-1:0] size,
                                input logic [FIELD_ADDR_W-1:0] addr,
                                output alloc_reply_type r);
      longint unsigned         bytes;
      int                      k;
      logic [FIELD_ADDR_W-1:0] s;
      logic [LEN_W-1:0]        l;
      r = '{status: ST_OK, addr: '0, size: '0, valid: 1'b0};
      case (kind)
         KIND_INIT: begin
            bytes = longint'(region_pages) * PAGE_BYTES;
            if (bytes > SIZE_MAX)
               bytes = SIZE_MAX;
            free_base[0] = '0;
            free_len[0]  = LEN_W'(bytes);
            free_used    = 1;
            live_used    = 0;
            table_ready  = 1'b1;
         end
         KIND_ALLOC: begin
            if (size == '0) begin
               r.status = ST_ZERO_SIZE;
            end else if (!table_ready) begin
               r.status = ST_NO_INIT;
            end else begin
               k = 0;
               while (k < free_used && free_len[k] < size)
                  k++;
               if (k >= free_used) begin
                  r.status = ST_NO_FIT;
               end else if (live_used >= LIVE_ENTRIES) begin
                  r.status = ST_TABLE_FULL;
               end else begin
                  for (int i = live_used; i > 0; i--) begin
                     live_base[i] = live_base[i-1];
                     live_len[i]  = live_len[i-1];
                  end
                  live_base[0] = free_base[k];
                  live_len[0]  = size;
                  live_used++;
                  r.addr       = free_base[k];
                  free_base[k] = FIELD_ADDR_W'((longint'(free_base[k]) + longint'(size))
                                               & ADDR_MASK);
                  free_len[k]  = free_len[k] - size;
               end
            end
         end
         KIND_FREE: begin
            if (!table_ready) begin
               r.status = ST_NO_INIT;
            end else begin
               k = find_live_block(addr);
               if (k >= live_used) begin
                  r.status = ST_NOT_FOUND;
               end else if (free_used >= FREE_ENTRIES) begin
                  r.status = ST_TABLE_FULL;
               end else begin
                  s = live_base[k];
                  l = live_len[k];
                  for (int i = k; i + 1 < live_used; i++) begin
                     live_base[i] = live_base[i+1];
                     live_len[i]  = live_len[i+1];
                  end
                  live_used--;
                  for (int i = free_used; i > 0; i--) begin
                     free_base[i] = free_base[i-1];
                     free_len[i]  = free_len[i-1];
                  end
                  free_base[0] = s;
                  free_len[0]  = l;
                  free_used++;
               end
            end
         end
         default: begin
            if (!table_ready) begin
               r.status = ST_NO_INIT;
            end else begin
               k = find_live_block(addr);
               if (k >= live_used) begin
                  r.status = ST_NOT_FOUND;
               end else begin
                  r.valid = 1'b1;
                  r.size  = live_len[k];
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      alloc_reply_type want;
      if (reset) begin
         free_used    = 0;
         live_used    = 0;
         table_ready  = 1'b0;
         region_pages = PAGES_RESET;
         expected_replies.delete();
      end else begin
         // responses first, so a request taken on the same edge cannot match it
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               flag_mismatch("unexpected response status", rsp_status, 0);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch("status", rsp_status, want.status);
               if (rsp_result_addr !== want.addr)
                  flag_mismatch("result_addr", rsp_result_addr, want.addr);
               if (rsp_result_size !== want.size)
                  flag_mismatch("result_size", rsp_result_size, want.size);
               if (rsp_is_valid !== want.valid)
                  flag_mismatch("is_valid", rsp_is_valid, want.valid);
            end
         end
         if (csr_valid && csr_ready)
            region_pages = csr_data;
         if (start && !busy) begin
            predict_reply(kind_type'(req_kind), req_request_size, req_block_addr, want);
            expected_replies.push_back(want);
         end
      end
      outstanding <= expected_replies.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top level: makes requests and region size writes, and gives the verdict.
// All prediction and comparison sits in the reply checker beside the block.
module testbench;
   import ffba_pkg::*;

   localparam int FREE_ENTRIES = 16;
   localparam int LIVE_ENTRIES = 16;
   localparam int PAGE_BYTES   = 4096;
   localparam int ADDR_BITS    = 20;
   localparam int ITEM_TARGET  = 1500;
   // tail wait outlasts the longest request, with margin
   localparam int TAIL_CYCLES  = FREE_ENTRIES + LIVE_ENTRIES + 8;
   // longest quiet stretch of a correct run is the tail wait or a drain
   localparam int STALL_LIMIT  = 2000;

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    start            = 1'b0;
   logic [KIND_W-1:0]       req_kind         = '0;
   logic [LEN_W-1:0]        req_request_size = '0;
   logic [FIELD_ADDR_W-1:0] req_block_addr   = '0;
   logic                    csr_valid        = 1'b0;
   logic [PAGES_W-1:0]      csr_data         = '0;
   logic                    busy;
   logic                    rsp_valid;
   logic [STATUS_W-1:0]     rsp_status;
   logic [FIELD_ADDR_W-1:0] rsp_result_addr;
   logic [LEN_W-1:0]        rsp_result_size;
   logic                    rsp_is_valid;
   logic                    csr_ready;
   int                      mismatches;
   int                      outstanding;

   // offsets handed back by the block; free and query requests mostly aim here
   logic [FIELD_ADDR_W-1:0] addr_pool [$];
   int                      items_sent   = 0;
   int                      burst_left   = 1;
   int unsigned             region_bytes = PAGES_RESET * PAGE_BYTES;

   initial begin
      forever #5 clock = ~clock;
   end

   first_fit_block_allocator_unit #(
      .FREE_ENTRIES (FREE_ENTRIES),
      .LIVE_ENTRIES (LIVE_ENTRIES),
      .PAGE_BYTES   (PAGE_BYTES),
      .ADDR_BITS    (ADDR_BITS)
   ) dut (
      .clock, .reset, .start, .busy,
      .req_kind, .req_request_size, .req_block_addr,
      .rsp_valid, .rsp_status, .rsp_result_addr, .rsp_result_size, .rsp_is_valid,
      .csr_valid, .csr_ready, .csr_data
   );

   ffba_reply_checker #(
      .FREE_ENTRIES (FREE_ENTRIES),
      .LIVE_ENTRIES (LIVE_ENTRIES),
      .PAGE_BYTES   (PAGE_BYTES),
      .ADDR_BITS    (ADDR_BITS)
   ) reply_check (
      .clock, .reset, .start, .busy,
      .req_kind, .req_request_size, .req_block_addr,
      .rsp_valid, .rsp_status, .rsp_result_addr, .rsp_result_size, .rsp_is_valid,
      .csr_valid, .csr_ready, .csr_data,
      .mismatches, .outstanding
   );

   // harvest offsets from good responses (frees and queries add 0, a live offset
   // often enough); the pool is only a stimulus hint, never a reference
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_status == ST_OK) begin
         addr_pool.push_back(rsp_result_addr);
         if (addr_pool.size() > 24)
            void'(addr_pool.pop_front());
      end
   end

   // one request; start stays high across a burst, drops for a random gap after it
   task automatic issue(input kind_type kind, input logic [LEN_W-1:0] size,
                        input logic [FIELD_ADDR_W-1:0] addr);
      int gap;
      req_kind         <= kind;
      req_request_size <= size;
      req_block_addr   <= addr;
      start            <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         // mostly short bursts, now and then a long unbroken run
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // hold off until every outstanding request has been answered
   task automatic wait_idle();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   // region size write; only called with the block idle
   task automatic set_pages(input logic [PAGES_W-1:0] pages);
      csr_valid <= 1'b1;
      csr_data  <= pages;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid    <= 1'b0;
      region_bytes  = pages * PAGE_BYTES;
   endtask

   function automatic logic [LEN_W-1:0] pick_size();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 4)  return '0;
      if (r < 6)  return SIZE_MAX;
      if (r < 8)  return LEN_W'(1 << 20);
      if (r < 12) return LEN_W'($urandom);
      if (r < 40) return LEN_W'($urandom_range(1, 64));
      if (r < 75) return LEN_W'($urandom_range(1, PAGE_BYTES));
      if (r < 90) return LEN_W'($urandom_range(1, region_bytes / 4 + 1));
      return LEN_W'($urandom_range(1, region_bytes + 1));
   endfunction

   function automatic logic [FIELD_ADDR_W-1:0] pick_addr();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (addr_pool.size() != 0 && r < 70)
         return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
      if (r < 80) return FIELD_ADDR_W'($urandom);
      if (r < 85) return '1;
      if (r < 90) return '0;
      return FIELD_ADDR_W'($urandom_range(0, 4096));
   endfunction

   // allocation-heavy mix so that both tables fill and hit the full case
   task automatic random_request();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 3)
         issue(KIND_INIT, LEN_W'($urandom), FIELD_ADDR_W'($urandom));
      else if (r < 48)
         issue(KIND_ALLOC, pick_size(), FIELD_ADDR_W'($urandom));
      else if (r < 73)
         issue(KIND_FREE, LEN_W'($urandom), pick_addr());
      else
         issue(KIND_QUERY, LEN_W'($urandom), pick_addr());
   endtask

   initial begin : stimulus
      int                 run_len;
      logic [PAGES_W-1:0] pages;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // before init: zero size outranks the init check, the rest report no init
      issue(KIND_ALLOC, '0, '0);
      issue(KIND_ALLOC, LEN_W'(5), '0);
      issue(KIND_FREE,  '0, '0);
      issue(KIND_QUERY, '0, '1);
      // default region of 256 pages is exactly the whole address space
      issue(KIND_INIT,  '0, '0);
      issue(KIND_ALLOC, LEN_W'(1), '0);
      issue(KIND_QUERY, '0, '0);
      issue(KIND_ALLOC, SIZE_MAX, '0);                      // no fit
      issue(KIND_ALLOC, LEN_W'(20'hFFFFF), '0);             // takes the rest, start wraps
      issue(KIND_QUERY, '0, FIELD_ADDR_W'(1));
      issue(KIND_ALLOC, LEN_W'(1), '0);                     // zero-length remnant: no fit
      issue(KIND_FREE,  '0, '0);
      issue(KIND_FREE,  '0, '0);                            // already freed: not found
      issue(KIND_QUERY, '0, '0);
      issue(KIND_ALLOC, LEN_W'(1), '0);                     // reuses the freed head entry
      issue(KIND_INIT,  '0, '0);                            // repeated init
      wait_idle();
      // largest region exceeds the address space: offsets wrap and repeat
      set_pages('1);
      issue(KIND_INIT,  '0, '0);
      issue(KIND_ALLOC, LEN_W'(20'h80000), '0);
      issue(KIND_ALLOC, LEN_W'(20'h80000), '0);
      issue(KIND_ALLOC, LEN_W'(20'h7F000), '0);             // lands on offset 0 again
      issue(KIND_QUERY, '0, '0);                            // head-nearest duplicate
      issue(KIND_FREE,  '0, '0);
      issue(KIND_QUERY, '0, '0);
      wait_idle();
      // empty region: a single zero-length free entry
      set_pages('0);
      issue(KIND_INIT,  '0, '0);
      issue(KIND_ALLOC, LEN_W'(1), '0);

      // --- random part: runs of requests after a fresh init, region varied ---
      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         case ($urandom_range(0, 7))
            0:       pages = '0;
            1:       pages = 9'd1;
            2:       pages = 9'd2;
            3:       pages = '1;
            4:       pages = PAGES_RESET;
            default: pages = PAGES_W'($urandom_range(1, 511));
         endcase
         set_pages(pages);
         issue(KIND_INIT, LEN_W'($urandom), FIELD_ADDR_W'($urandom));
         run_len = $urandom_range(40, 120);
         repeat (run_len) begin
            random_request();
            // occasional drain so a request meets a fully quiet block
            if ($urandom_range(0, 49) == 0)
               wait_idle();
         end
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("PASS first_fit_block_allocator_unit");
      else
         $display("FAIL first_fit_block_allocator_unit");
      $finish;
   end

   // ends the run if nothing moves on any channel for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAIL first_fit_block_allocator_unit");
      $finish;
   end

endmodule
